FILE: design/bscca_pkg.sv
// Shared types, field widths and default parameters for the bit-sliced column code access block.
`default_nettype none

package bscca_pkg;

    localparam int IDX_W  = 14;
    localparam int CODE_W = 8;

    localparam int DEF_CODE_BITS       = 8;
    localparam int DEF_WORD_BITS       = 64;
    localparam int DEF_GROUP_BITS      = 4;
    localparam int DEF_CODES_PER_BLOCK = 1024;
    localparam int DEF_BLOCK_COUNT     = 16;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  tuple_index;
        logic [CODE_W-1:0] write_code;
    } req_t;

    typedef struct packed {
        logic [CODE_W-1:0] read_code;
        logic              was_write;
        logic              out_of_range;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_BLK,
        S_DIV_SEG,
        S_ACCESS,
        S_DRAIN,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: design/bscca_if.sv
// Valid/ready channel interfaces for access requests and their results.
`default_nettype none

interface bscca_req_if;
    logic             valid;
    logic             ready;
    bscca_pkg::req_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bscca_rsp_if;
    logic             valid;
    logic             ready;
    bscca_pkg::rsp_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/bscca_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module bscca_div #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 11
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quo,
    output logic      [DEN_W-1:0] rem
);
    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [NUM_W-1:0]  quo_reg,   quo_next;
    logic [DEN_W-1:0]  rem_reg,   rem_next;
    logic [DEN_W-1:0]  den_reg,   den_next;
    logic [DEN_W:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in, subtract when it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: design/bscca_plane_mem.sv
// Bit-plane word memory with single-bit writes and a clearing sweep after reset.
`default_nettype none

module bscca_plane_mem #(
    parameter int WORD_BITS = 64,
    parameter int DEPTH     = 2048,
    parameter int ADDR_W    = 11,
    parameter int OFF_W     = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    addr,
    input  wire logic [OFF_W-1:0]     off,
    input  wire logic                 wr_bit,
    output logic      [WORD_BITS-1:0] rd_word,
    output logic                      clr_busy
);
    logic [WORD_BITS-1:0] plane_mem [DEPTH];
    logic [WORD_BITS-1:0] rd_word_reg;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic                 clr_busy_reg, clr_busy_next;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            plane_mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            plane_mem[addr][off] <= wr_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= plane_mem[addr];
        end
    end

    assign rd_word  = rd_word_reg;
    assign clr_busy = clr_busy_reg;

endmodule

`default_nettype wire

FILE: design/bit_sliced_column_code_access.sv
// Bit-sliced column code access: read or write one code in a vertical bit-plane store.
//
// Requests arrive on req (mode, tuple_index, write_code); one result per request leaves
// on rsp (read_code, was_write, out_of_range). Both are valid/ready channels.
// After reset the store is swept to zero, one word per cycle, over BLOCK_COUNT * CODE_BITS *
// ceil(CODES_PER_BLOCK / WORD_BITS) words (2048 at defaults); req.ready stays low then.
// One request is in flight at a time. An in-range request splits its index with a
// bit-serial divider used twice, sets up the first word address, then walks
// the code bits one memory word per cycle, most significant first: a write sets one
// bit per word, a read gathers one bit per word and then drains the last read data.
// An out-of-range index skips the divider and the store and answers with read_code
// zero. The single memory port and the divider serve one request at a time.
// The result sits in an output register; if rsp.ready is low it waits there, and the
// next finished result waits until the register is taken. A new request is accepted
// as soon as the previous one has moved to the output register.
`default_nettype none

module bit_sliced_column_code_access #(
    parameter int CODE_BITS       = bscca_pkg::DEF_CODE_BITS,
    parameter int WORD_BITS       = bscca_pkg::DEF_WORD_BITS,
    parameter int GROUP_BITS      = bscca_pkg::DEF_GROUP_BITS,
    parameter int CODES_PER_BLOCK = bscca_pkg::DEF_CODES_PER_BLOCK,
    parameter int BLOCK_COUNT     = bscca_pkg::DEF_BLOCK_COUNT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bscca_req_if.sink    req,
    bscca_rsp_if.source  rsp
);
    import bscca_pkg::*;

    localparam int FULL_GROUPS = CODE_BITS / GROUP_BITS;
    localparam int LAST_BITS   = CODE_BITS % GROUP_BITS;
    localparam int SEGS        = (CODES_PER_BLOCK + WORD_BITS - 1) / WORD_BITS;
    localparam int BLOCK_WORDS = CODE_BITS * SEGS;
    localparam int STORE_WORDS = BLOCK_COUNT * BLOCK_WORDS;
    localparam int TOTAL_CODES = BLOCK_COUNT * CODES_PER_BLOCK;
    localparam int LAST_ORIGIN = FULL_GROUPS * SEGS * GROUP_BITS;
    localparam int GROUP_STEP  = (SEGS - 1) * GROUP_BITS + 1;

    localparam int ADDR_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int OFF_W  = $clog2(WORD_BITS);
    localparam int BLK_W  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int SEG_W  = (SEGS > 1) ? $clog2(SEGS) : 1;
    localparam int K_W    = (GROUP_BITS > 1) ? $clog2(GROUP_BITS) : 1;
    localparam int G_W    = (FULL_GROUPS > 1) ? $clog2(FULL_GROUPS + 1) : 1;
    localparam int B_W    = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
    localparam int DEN_W  = $clog2(CODES_PER_BLOCK + 1);
    localparam int TOT_W  = $clog2(TOTAL_CODES + 1);
    localparam int CMP_W  = (TOT_W > IDX_W) ? TOT_W : IDX_W;

    state_t state_reg, state_next;

    logic                 mode_reg,      mode_next;
    logic                 oor_reg,       oor_next;
    logic [BLK_W-1:0]     blk_reg,       blk_next;
    logic [OFF_W-1:0]     off_reg,       off_next;
    logic [ADDR_W-1:0]    addr_reg,      addr_next;
    logic [ADDR_W-1:0]    last_base_reg, last_base_next;
    logic [K_W-1:0]       k_reg,         k_next;
    logic [G_W-1:0]       g_reg,         g_next;
    logic                 in_last_reg,   in_last_next;
    logic [B_W-1:0]       bit_cnt_reg,   bit_cnt_next;
    logic [CODE_BITS-1:0] wr_shift_reg,  wr_shift_next;
    logic [CODE_BITS-1:0] gather_reg,    gather_next;
    logic                 rd_pend_reg,   rd_pend_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_data_reg,  rsp_data_next;

    logic                 div_start;
    logic [IDX_W-1:0]     div_num;
    logic [DEN_W-1:0]     div_den;
    logic                 div_done;
    logic [IDX_W-1:0]     div_quo;
    logic [DEN_W-1:0]     div_rem;

    logic                 mem_rd_en;
    logic                 mem_wr_en;
    logic                 mem_wr_bit;
    logic [WORD_BITS-1:0] mem_rd_word;
    logic                 mem_clr_busy;

    logic [SEG_W-1:0]     seg;
    logic [OFF_W-1:0]     pos;
    logic [ADDR_W-1:0]    base;
    logic                 req_oor;
    logic                 req_fire;

    bscca_div #(
        .NUM_W (IDX_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    bscca_plane_mem #(
        .WORD_BITS (WORD_BITS),
        .DEPTH     (STORE_WORDS),
        .ADDR_W    (ADDR_W),
        .OFF_W     (OFF_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (mem_rd_en),
        .wr_en    (mem_wr_en),
        .addr     (addr_reg),
        .off      (off_reg),
        .wr_bit   (mem_wr_bit),
        .rd_word  (mem_rd_word),
        .clr_busy (mem_clr_busy)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign req_oor   = CMP_W'(req.payload.tuple_index) >= CMP_W'(TOTAL_CODES);

    assign seg  = div_quo[SEG_W-1:0];
    assign pos  = div_rem[OFF_W-1:0];
    assign base = ADDR_W'(blk_reg * BLOCK_WORDS);

    assign mem_wr_bit = wr_shift_reg[CODE_BITS-1];

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        oor_next       = oor_reg;
        blk_next       = blk_reg;
        off_next       = off_reg;
        addr_next      = addr_reg;
        last_base_next = last_base_reg;
        k_next         = k_reg;
        g_next         = g_reg;
        in_last_next   = in_last_reg;
        bit_cnt_next   = bit_cnt_reg;
        wr_shift_next  = wr_shift_reg;
        gather_next    = gather_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        div_start      = 1'b0;
        div_num        = req.payload.tuple_index;
        div_den        = DEN_W'(CODES_PER_BLOCK);
        mem_rd_en      = 1'b0;
        mem_wr_en      = 1'b0;

        // read data lands in the cycle after the read is issued
        if (rd_pend_reg)
        begin
            gather_next = (gather_reg << 1) | CODE_BITS'(mem_rd_word[off_reg]);
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                if (!mem_clr_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    mode_next     = req.payload.mode;
                    oor_next      = req_oor;
                    wr_shift_next = CODE_BITS'(req.payload.write_code);
                    gather_next   = '0;
                    if (req_oor)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV_BLK;
                    end
                end
            end
            S_DIV_BLK:
            begin
                if (div_done)
                begin
                    blk_next   = BLK_W'(div_quo);
                    div_start  = 1'b1;
                    div_num    = IDX_W'(div_rem);
                    div_den    = DEN_W'(WORD_BITS);
                    state_next = S_DIV_SEG;
                end
            end
            S_DIV_SEG:
            begin
                if (div_done)
                begin
                    off_next       = OFF_W'(WORD_BITS - 1) - pos;
                    last_base_next = base + ADDR_W'(LAST_ORIGIN) + ADDR_W'(seg * LAST_BITS);
                    if (FULL_GROUPS > 0)
                    begin
                        addr_next    = base + ADDR_W'(seg * GROUP_BITS);
                        in_last_next = 1'b0;
                    end
                    else
                    begin
                        addr_next    = base + ADDR_W'(seg * LAST_BITS);
                        in_last_next = 1'b1;
                    end
                    k_next       = '0;
                    g_next       = '0;
                    bit_cnt_next = '0;
                    state_next   = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                mem_wr_en     = mode_reg;
                mem_rd_en     = !mode_reg;
                wr_shift_next = wr_shift_reg << 1;
                bit_cnt_next  = bit_cnt_reg + 1'b1;
                // step to the next word: within a group, across to the next full
                // group, or over to the shorter last group
                if (!in_last_reg && (k_reg == K_W'(GROUP_BITS - 1)))
                begin
                    k_next = '0;
                    if (g_reg == G_W'(FULL_GROUPS - 1))
                    begin
                        in_last_next = 1'b1;
                        addr_next    = last_base_reg;
                    end
                    else
                    begin
                        g_next    = g_reg + 1'b1;
                        addr_next = addr_reg + ADDR_W'(GROUP_STEP);
                    end
                end
                else
                begin
                    k_next    = k_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                if (bit_cnt_reg == B_W'(CODE_BITS - 1))
                begin
                    state_next = mode_reg ? S_DONE : S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_data_next.read_code    = (mode_reg || oor_reg) ? '0
                                                 : CODE_W'(gather_reg);
                    rsp_data_next.was_write    = mode_reg;
                    rsp_data_next.out_of_range = oor_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_pend_next = mem_rd_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            bit_cnt_reg   <= '0;
            in_last_reg   <= 1'b0;
            k_reg         <= '0;
            g_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            rd_pend_reg   <= rd_pend_next;
            bit_cnt_reg   <= bit_cnt_next;
            in_last_reg   <= in_last_next;
            k_reg         <= k_next;
            g_reg         <= g_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        oor_reg       <= oor_next;
        blk_reg       <= blk_next;
        off_reg       <= off_next;
        addr_reg      <= addr_next;
        last_base_reg <= last_base_next;
        wr_shift_reg  <= wr_shift_next;
        gather_reg    <= gather_next;
        rsp_data_reg  <= rsp_data_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

`ifndef ASSERT_OFF
    // no request may be taken while the store is still being cleared
    a_no_req_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mem_clr_busy |-> !req.ready)
        else $error("request accepted during clearing sweep");

    // the single memory port never reads and writes in the same cycle
    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> !mem_rd_en)
        else $error("memory read and write issued together");

    // results for writes and out-of-range indexes carry no code
    a_no_code_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.payload.was_write || rsp.payload.out_of_range))
            |-> (rsp.payload.read_code == '0))
        else $error("nonzero read_code on write or out-of-range result");

    // an accepted request leaves the idle state
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != S_IDLE))
        else $error("still idle after accepting a request");

    // the divider is only started from idle or when the block split finishes
    a_div_start_legal: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (req_fire || (state_reg == S_DIV_BLK && div_done)))
        else $error("divider started out of sequence");
`endif

endmodule

`default_nettype wire

FILE: sim/bit_sliced_column_code_access_test.sv
// Testbench for the bit-sliced column code access block: directed, random and backpressure tests.
`timescale 1ns / 100ps

module bit_sliced_column_code_access_test;

    import bscca_pkg::*;

    localparam int CODE_BITS       = DEF_CODE_BITS;
    localparam int WORD_BITS       = DEF_WORD_BITS;
    localparam int GROUP_BITS      = DEF_GROUP_BITS;
    localparam int CODES_PER_BLOCK = DEF_CODES_PER_BLOCK;
    localparam int BLOCK_COUNT     = DEF_BLOCK_COUNT;

    localparam int FULL_GROUPS = CODE_BITS / GROUP_BITS;
    localparam int LAST_BITS   = CODE_BITS % GROUP_BITS;
    localparam int SEGS        = (CODES_PER_BLOCK + WORD_BITS - 1) / WORD_BITS;
    localparam int BLOCK_WORDS = CODE_BITS * SEGS;
    localparam int STORE_WORDS = BLOCK_COUNT * BLOCK_WORDS;
    localparam int TOTAL_CODES = BLOCK_COUNT * CODES_PER_BLOCK;
    localparam int MAX_INDEX   = (1 << IDX_W) - 1;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_HOLD    = 300;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bscca_req_if req_ch ();
    bscca_rsp_if rsp_ch ();

    bit_sliced_column_code_access #(
        .CODE_BITS       (CODE_BITS),
        .WORD_BITS       (WORD_BITS),
        .GROUP_BITS      (GROUP_BITS),
        .CODES_PER_BLOCK (CODES_PER_BLOCK),
        .BLOCK_COUNT     (BLOCK_COUNT)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the bit-plane store and the answers still owed by the block.
    logic [63:0] plane_shadow [0:STORE_WORDS-1];
    rsp_t        answers_due [$];
    int          written_index [$];

    int error_count    = 0;
    int answers_seen   = 0;
    int reads_sent     = 0;
    int writes_sent    = 0;
    int oor_sent       = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    // Applies one access to the shadow store and returns the answer it must produce.
    function automatic rsp_t access_bit_planes(logic mode, logic [IDX_W-1:0] idx,
                                               logic [CODE_W-1:0] code);
        rsp_t         answer;
        int unsigned  blk, in_blk, seg, pos, off, addr, grp, k, sh;
        logic [31:0]  gathered;
        logic [31:0]  code_wide;
        answer    = '0;
        gathered  = '0;
        code_wide = {24'b0, code};
        answer.was_write = mode;
        if (int'(idx) >= TOTAL_CODES)
        begin
            answer.out_of_range = 1'b1;
            return answer;
        end
        blk    = idx / CODES_PER_BLOCK;
        in_blk = idx % CODES_PER_BLOCK;
        seg    = in_blk / WORD_BITS;
        pos    = in_blk % WORD_BITS;
        off    = WORD_BITS - 1 - pos;
        for (int b = 0; b < CODE_BITS; b++)
        begin
            grp = b / GROUP_BITS;
            k   = b % GROUP_BITS;
            sh  = CODE_BITS - 1 - b;
            if (grp < FULL_GROUPS)
                addr = blk * BLOCK_WORDS + grp * SEGS * GROUP_BITS + seg * GROUP_BITS + k;
            else
                addr = blk * BLOCK_WORDS + FULL_GROUPS * SEGS * GROUP_BITS
                       + seg * LAST_BITS + k;
            if (addr < STORE_WORDS)
            begin
                if (mode == MODE_WRITE)
                    plane_shadow[addr][off] = (sh < 32) ? code_wide[sh] : 1'b0;
                else if (sh < 32)
                    gathered[sh] = plane_shadow[addr][off];
            end
        end
        if (mode == MODE_READ)
            answer.read_code = gathered[CODE_W-1:0];
        return answer;
    endfunction

    // Offers one transaction after a random gap; valid stays high for a back-to-back next one.
    task automatic send_access(input logic mode, input logic [IDX_W-1:0] idx,
                               input logic [CODE_W-1:0] code);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid               <= 1'b1;
        req_ch.payload.mode        <= mode;
        req_ch.payload.tuple_index <= idx;
        req_ch.payload.write_code  <= code;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        answers_due.push_back(access_bit_planes(mode, idx, code));
        if (int'(idx) >= TOTAL_CODES)
            oor_sent++;
        if (mode == MODE_WRITE)
            writes_sent++;
        else
            reads_sent++;
    endtask

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            answers_seen++;
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %p",
                         $time, rsp_ch.payload);
                error_count++;
            end
            else
            begin
                rsp_t want;
                want = answers_due.pop_front();
                if (rsp_ch.payload.read_code !== want.read_code)
                begin
                    $display("%0t: read_code expected %02h actual %02h",
                             $time, want.read_code, rsp_ch.payload.read_code);
                    error_count++;
                end
                if (rsp_ch.payload.was_write !== want.was_write)
                begin
                    $display("%0t: was_write expected %0b actual %0b",
                             $time, want.was_write, rsp_ch.payload.was_write);
                    error_count++;
                end
                if (rsp_ch.payload.out_of_range !== want.out_of_range)
                begin
                    $display("%0t: out_of_range expected %0b actual %0b",
                             $time, want.out_of_range, rsp_ch.payload.out_of_range);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d transactions still owed",
                 cycle_count, answers_due.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Empty store reads, extreme indices and codes, neighbors and block edges.
    task automatic test_directed();
        send_access(MODE_READ,  14'd0,            8'h00);
        send_access(MODE_READ,  IDX_W'(MAX_INDEX), 8'hFF);
        send_access(MODE_WRITE, 14'd0,            8'hFF);
        send_access(MODE_READ,  14'd0,            8'h00);
        send_access(MODE_WRITE, IDX_W'(MAX_INDEX), 8'hA5);
        send_access(MODE_READ,  IDX_W'(MAX_INDEX), 8'h00);
        send_access(MODE_WRITE, 14'd0,            8'h00);
        send_access(MODE_READ,  14'd0,            8'h00);
        send_access(MODE_WRITE, 14'd63,           8'h80);
        send_access(MODE_WRITE, 14'd64,           8'h01);
        send_access(MODE_WRITE, 14'd65,           8'h5A);
        send_access(MODE_READ,  14'd63,           8'h00);
        send_access(MODE_READ,  14'd64,           8'h00);
        send_access(MODE_READ,  14'd65,           8'h00);
        send_access(MODE_WRITE, 14'd1023,         8'hC3);
        send_access(MODE_WRITE, 14'd1024,         8'h3C);
        send_access(MODE_READ,  14'd1023,         8'h00);
        send_access(MODE_READ,  14'd1024,         8'hFF);
        send_access(MODE_WRITE, 14'h2AAA,         8'h55);
        send_access(MODE_WRITE, 14'h1555,         8'hAA);
        send_access(MODE_READ,  14'h2AAA,         8'h00);
        send_access(MODE_READ,  14'h1555,         8'h00);
        send_access(MODE_WRITE, IDX_W'(MAX_INDEX), 8'h00);
        send_access(MODE_READ,  IDX_W'(MAX_INDEX), 8'h00);
    endtask

    // Mostly revisits recent writes and their bit-flip neighbors so reads return data.
    task automatic test_random_mix(input int count);
        int unsigned      pick;
        logic [IDX_W-1:0] idx;
        logic             mode;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (written_index.size() == 0 || pick < 30)
                idx = IDX_W'($urandom_range(MAX_INDEX));
            else if (pick < 75)
                idx = IDX_W'(written_index[$urandom_range(written_index.size() - 1)]);
            else
                idx = IDX_W'(written_index[$urandom_range(written_index.size() - 1)])
                      ^ IDX_W'(1 << $urandom_range(IDX_W - 1));
            mode = ($urandom_range(99) < 45) ? MODE_WRITE : MODE_READ;
            send_access(mode, idx, CODE_W'($urandom_range(255)));
            if (mode == MODE_WRITE)
            begin
                written_index.push_back(int'(idx));
                if (written_index.size() > 48)
                    void'(written_index.pop_front());
            end
        end
    endtask

    // Receiver holds off for a long stretch while transactions keep coming.
    task automatic test_backpressure();
        hold_requests++;
        test_random_mix(14);
    endtask

    initial
    begin
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        for (int w = 0; w < STORE_WORDS; w++)
            plane_shadow[w] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();

        send_idle_pct = 27;
        recv_idle_pct = 68;
        test_random_mix(280);
        test_backpressure();

        send_idle_pct = 68;
        recv_idle_pct = 27;
        test_random_mix(270);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_mix(260);

        req_ch.valid <= 1'b0;
        while (answers_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d reads, %0d writes, %0d out-of-range accesses; %0d results checked",
                 reads_sent, writes_sent, oor_sent, answers_seen);
        $display("idle mixes 27/68, 68/27 and none, with two long receiver hold-offs");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
